/* design/nhms_pkg.sv */
// ----------------------------------------------------------------------------
// nhms_pkg
// Shared widths, codes and control/status types for the nearest Hamming
// member select block.
// ----------------------------------------------------------------------------
package nhms_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int POP_SIZE_DEF = 64;
  localparam int VEC_BITS_DEF = 64;

  // Fixed field widths
  localparam int IDX_W  = 6;
  localparam int DIST_W = 7;
  localparam int IN_W   = 64;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_ACTIVE_BITS = 1'b0;   // register index, from paddr[2]
  localparam logic [DIST_W-1:0] ACTIVE_BITS_RESET = 7'd64;

  // Item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic mem_we;      // write the loaded vector into the store
    logic mem_re;      // read the sampled slot
    logic cap_s1;      // capture slot and reference of an accepted sample
    logic cap_s2;      // capture the distance of the sample in stage one
    logic upd_valid;   // stage two holds a sample to weigh
    logic upd_first;   // that sample opens a selection
  } nhms_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic slot_ok;     // presented slot lies inside the population
  } nhms_stat_t;

endpackage

/* design/nearest_hamming_member_select.sv */
// ----------------------------------------------------------------------------
// nearest_hamming_member_select
// Picks the population slot nearest in Hamming distance to a reference.
// ----------------------------------------------------------------------------
// Usage
//   Items enter on the command channel: an item transfers at a rising edge
//   with start high and busy low. busy stays low, so an item may follow in
//   every cycle. func selects a load (write entry_bits into slot entry_index)
//   or a sample (weigh slot entry_index against reference_bits).
//   A selection is a run of samples opened by first_sample and closed by
//   last_sample. The last sample raises done for exactly one cycle, with
//   chosen_index and chosen_distance valid in that cycle; done and the held
//   best are both registered from stage two of the sample pipeline.
//   Throughput is one item per cycle, set by the single read port of the
//   population store; the sample pipeline is read, count, update.
//   The receiver takes every result; there is no hold-off. active_bits is
//   to be written over the APB port (address 0) only while the block is
//   idle, which it does not enforce; only that many low vector bits are
//   compared. Reset (synchronous, active high) empties the pipeline, sets
//   the held best slot and distance to zero and active_bits to 64. The
//   store is not cleared: a slot must be loaded before it is sampled.
// ----------------------------------------------------------------------------
module nearest_hamming_member_select
  import nhms_pkg::*;
#(
  parameter int POP_SIZE = POP_SIZE_DEF,
  parameter int VEC_BITS = VEC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Command channel
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [IN_W-1:0]   entry_bits,
  input  logic [IN_W-1:0]   reference_bits,
  input  logic              first_sample,
  input  logic              last_sample,
  // Result channel
  output logic              done,
  output logic [IDX_W-1:0]  chosen_index,
  output logic [DIST_W-1:0] chosen_distance,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  nhms_cmd_t         cmd;
  nhms_stat_t        stat;
  logic              accept;
  logic [DIST_W-1:0] active_bits;

  // The pipeline never backs up, so hold busy low
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration register; paddr[2] picks the register word
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bits <= ACTIVE_BITS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_BITS)) begin
      active_bits <= pwdata[DIST_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ACTIVE_BITS) ? APB_DW'(active_bits) : '0;

  nhms_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .func         (func),
    .first_sample (first_sample),
    .last_sample  (last_sample),
    .stat         (stat),
    .cmd          (cmd),
    .done         (done)
  );

  nhms_datapath #(
    .POP_SIZE (POP_SIZE),
    .VEC_BITS (VEC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .entry_index    (entry_index),
    .entry_bits     (entry_bits),
    .reference_bits (reference_bits),
    .active_bits    (active_bits),
    .best_index     (chosen_index),
    .best_distance  (chosen_distance)
  );

endmodule

/* design/nhms_ram.sv */
// ----------------------------------------------------------------------------
// nhms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module nhms_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/nhms_ctrl.sv */
// ----------------------------------------------------------------------------
// nhms_ctrl
// Pipeline controller: tracks accepted samples through the read, count and
// update stages and raises the result strobe.
// ----------------------------------------------------------------------------
module nhms_ctrl
  import nhms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       func,
  input  logic       first_sample,
  input  logic       last_sample,
  input  nhms_stat_t stat,
  output nhms_cmd_t  cmd,
  output logic       done
);

  logic is_sample;
  logic s1_valid;
  logic s1_first;
  logic s1_last;
  logic s2_valid;
  logic s2_first;
  logic s2_last;

  assign is_sample = accept && (func == FUNC_SAMPLE);

  always_comb begin
    cmd.mem_we    = accept && (func == FUNC_LOAD) && stat.slot_ok;
    cmd.mem_re    = is_sample;
    cmd.cap_s1    = is_sample;
    cmd.cap_s2    = s1_valid;
    cmd.upd_valid = s2_valid;
    cmd.upd_first = s2_first;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= is_sample;
      s2_valid <= s1_valid;
      done     <= s2_valid && s2_last;
    end
  end

  // Flags travel with their valid bits
  always_ff @(posedge clk) begin
    s1_first <= first_sample;
    s1_last  <= last_sample;
    s2_first <= s1_first;
    s2_last  <= s1_last;
  end

endmodule

/* design/nhms_datapath.sv */
// ----------------------------------------------------------------------------
// nhms_datapath
// Population store, masked Hamming distance and running minimum.
// ----------------------------------------------------------------------------
module nhms_datapath
  import nhms_pkg::*;
#(
  parameter int POP_SIZE = POP_SIZE_DEF,
  parameter int VEC_BITS = VEC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  nhms_cmd_t         cmd,
  output nhms_stat_t        stat,
  input  logic [IDX_W-1:0]  entry_index,
  input  logic [IN_W-1:0]   entry_bits,
  input  logic [IN_W-1:0]   reference_bits,
  input  logic [DIST_W-1:0] active_bits,
  output logic [IDX_W-1:0]  best_index,
  output logic [DIST_W-1:0] best_distance
);

  localparam int AW   = $clog2(POP_SIZE);
  localparam int LVLS = $clog2(IN_W);

  logic [AW-1:0]       addr;
  logic [VEC_BITS-1:0] rdata;

  // Stage one: slot, reference and range flag beside the RAM read
  logic [IDX_W-1:0]    s1_index;
  logic                s1_ok;
  logic [VEC_BITS-1:0] s1_ref;

  // Stage two: distance of the sample
  logic [IDX_W-1:0]    s2_index;
  logic [DIST_W-1:0]   s2_dist;

  logic [VEC_BITS-1:0] vec;
  logic [IN_W-1:0]     diff;
  logic [DIST_W-1:0]   pop_sum [LVLS+1][IN_W];
  logic [DIST_W-1:0]   sample_dist;

  assign stat.slot_ok = 32'(entry_index) < 32'(POP_SIZE);
  assign addr         = AW'(entry_index);

  nhms_ram #(
    .WIDTH (VEC_BITS),
    .DEPTH (POP_SIZE)
  ) u_store (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (addr),
    .wdata (entry_bits[VEC_BITS-1:0]),
    .re    (cmd.mem_re),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_s1) begin
      s1_index <= entry_index;
      s1_ok    <= stat.slot_ok;
      s1_ref   <= reference_bits[VEC_BITS-1:0];
    end
  end

  // A slot beyond the population reads as all zeros; the popcount is a
  // pairwise adder tree over the masked difference
  always_comb begin
    vec  = s1_ok ? rdata : '0;
    diff = '0;
    for (int i = 0; i < VEC_BITS; i++) begin
      diff[i] = (vec[i] ^ s1_ref[i]) && (DIST_W'(i) < active_bits);
    end
    pop_sum = '{default: '0};
    for (int i = 0; i < IN_W; i++) begin
      pop_sum[0][i] = DIST_W'(diff[i]);
    end
    for (int k = 1; k <= LVLS; k++) begin
      for (int j = 0; j < (IN_W >> k); j++) begin
        pop_sum[k][j] = pop_sum[k-1][2*j] + pop_sum[k-1][2*j+1];
      end
    end
    sample_dist = pop_sum[LVLS][0];
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_s2) begin
      s2_index <= s1_index;
      s2_dist  <= sample_dist;
    end
  end

  // Keep the earliest sample on a tie: replace only on a strictly smaller distance
  always_ff @(posedge clk) begin
    if (rst) begin
      best_index    <= '0;
      best_distance <= '0;
    end else if (cmd.upd_valid && (cmd.upd_first || (s2_dist < best_distance))) begin
      best_index    <= s2_index;
      best_distance <= s2_dist;
    end
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the nearest Hamming member select block. Loads
// and selection samples go in on the command channel with random gaps. A
// behavioural copy of the population store, the running minimum and the
// compare width forecasts every selection result, and each done strobe is
// checked against the oldest forecast. The compare width is reprogrammed
// over APB between phases, and each write is read back.
// ----------------------------------------------------------------------------
module testbench
  import nhms_pkg::*;
();

  localparam int NSLOTS = POP_SIZE_DEF;
  localparam logic [APB_AW-1:0] ADDR_ACTIVE_BITS = {REG_ACTIVE_BITS, 2'b00};
  // Margin for done to follow the last sample through the pipeline
  localparam int SETTLE_CYCLES = 6;
  localparam int TARGET_ITEMS = 1050;
  localparam int LIMIT_NS = 1_000_000;

  typedef struct {
    logic              op;
    logic [IDX_W-1:0]  slot;
    logic [IN_W-1:0]   vec;
    logic [IN_W-1:0]   refv;
    logic              first;
    logic              last;
  } item_t;

  typedef struct {
    logic [IDX_W-1:0]  slot;
    logic [DIST_W-1:0] distance;
  } pick_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Command channel
  logic              start = 1'b0;
  logic              busy;
  logic              func = FUNC_LOAD;
  logic [IDX_W-1:0]  entry_index = '0;
  logic [IN_W-1:0]   entry_bits = '0;
  logic [IN_W-1:0]   reference_bits = '0;
  logic              first_sample = 1'b0;
  logic              last_sample = 1'b0;

  // Result channel
  logic              done;
  logic [IDX_W-1:0]  chosen_index;
  logic [DIST_W-1:0] chosen_distance;

  // Configuration port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Behavioural copy of the block's state
  logic [IN_W-1:0]   store_copy [NSLOTS];
  bit                loaded [NSLOTS];
  logic [IDX_W-1:0]  held_slot;
  logic [DIST_W-1:0] held_dist;
  logic [DIST_W-1:0] width_setting;

  // Selection results forecast but not yet seen on the result port
  pick_t             pending_picks[$];

  int                mismatch_count = 0;
  int                items_sent = 0;
  bit                steady = 1'b0;      // no gaps between transfers
  bit                start_high = 1'b0;  // mirrors the driven level of start

  nearest_hamming_member_select u_top (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .func            (func),
    .entry_index     (entry_index),
    .entry_bits      (entry_bits),
    .reference_bits  (reference_bits),
    .first_sample    (first_sample),
    .last_sample     (last_sample),
    .done            (done),
    .chosen_index    (chosen_index),
    .chosen_distance (chosen_distance),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Forecast
  // --------------------------------------------------------------------------

  // Hamming distance over the low width_setting bits; settings above the
  // vector width compare every bit, zero compares none.
  function automatic logic [DIST_W-1:0] masked_distance(logic [IN_W-1:0] a,
                                                        logic [IN_W-1:0] b);
    logic [IN_W-1:0] mask;
    if (width_setting >= IN_W) mask = '1;
    else mask = (64'd1 << width_setting) - 64'd1;
    return DIST_W'($countones((a ^ b) & mask));
  endfunction

  // Advance the copy by one transferred item and queue the pick it closes.
  function automatic void track_item(item_t it);
    logic [DIST_W-1:0] d;
    pick_t             p;
    if (it.op == FUNC_LOAD) begin
      // loads touch the store only, whatever their marks hold
      store_copy[it.slot] = it.vec;
      loaded[it.slot] = 1'b1;
    end else begin
      d = masked_distance(store_copy[it.slot], it.refv);
      // strict less-than: on a tie the earlier sample keeps its place
      if (it.first || d < held_dist) begin
        held_slot = it.slot;
        held_dist = d;
      end
      if (it.last) begin
        p.slot = held_slot;
        p.distance = held_dist;
        pending_picks.insert(pending_picks.size(), p);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Result check: the receiver cannot stall, so look at every edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    pick_t want;
    if (!rst && done) begin
      if (pending_picks.size() == 0) begin
        report_mismatch($sformatf("pick slot %0d distance %0d with no selection closed",
                                  chosen_index, chosen_distance));
      end else begin
        want = pending_picks.pop_front();
        if (chosen_index !== want.slot)
          report_mismatch($sformatf("chosen_index %0d, want %0d",
                                    chosen_index, want.slot));
        if (chosen_distance !== want.distance)
          report_mismatch($sformatf("chosen_distance %0d, want %0d",
                                    chosen_distance, want.distance));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item builders; fields that the operation ignores carry noise
  // --------------------------------------------------------------------------
  function automatic logic [IN_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t load_item(logic [IDX_W-1:0] s, logic [IN_W-1:0] v,
                                      logic f, logic l);
    item_t it;
    it.op = FUNC_LOAD;
    it.slot = s;
    it.vec = v;
    it.refv = rand64();
    it.first = f;
    it.last = l;
    return it;
  endfunction

  function automatic item_t sample_item(logic [IDX_W-1:0] s, logic [IN_W-1:0] r,
                                        logic f, logic l);
    item_t it;
    it.op = FUNC_SAMPLE;
    it.slot = s;
    it.vec = rand64();
    it.refv = r;
    it.first = f;
    it.last = l;
    return it;
  endfunction

  // Any slot already loaded; never sample one that was not
  function automatic logic [IDX_W-1:0] pick_loaded();
    logic [IDX_W-1:0] s;
    s = IDX_W'($urandom_range(0, NSLOTS - 1));
    while (!loaded[s]) s = s + 1'b1;
    return s;
  endfunction

  // Mostly a stored vector with a few bits flipped, so that distances are
  // small and ties are common; now and then an exact copy or pure noise.
  function automatic logic [IN_W-1:0] near_reference();
    logic [IN_W-1:0] base;
    int unsigned     roll;
    base = store_copy[pick_loaded()];
    roll = $urandom_range(0, 7);
    if (roll == 0) return base;
    if (roll == 1) return rand64();
    return base ^ (rand64() & rand64() & rand64());
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic lower_start();
    if (start_high) begin
      start <= 1'b0;
      start_high = 1'b0;
    end
  endtask

  // Drop start for a random stretch and scramble the idle fields meanwhile.
  task automatic pace();
    int unsigned n;
    n = draw_gap();
    if (n > 0) begin
      lower_start();
      func <= 1'($urandom);
      entry_index <= IDX_W'($urandom);
      entry_bits <= rand64();
      reference_bits <= rand64();
      first_sample <= 1'($urandom);
      last_sample <= 1'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one item, hold it until it transfers, then forecast it.
  // Called at a rising edge; start stays high if the next item follows.
  task automatic send_item(item_t it);
    start <= 1'b1;
    start_high = 1'b1;
    func <= it.op;
    entry_index <= it.slot;
    entry_bits <= it.vec;
    reference_bits <= it.refv;
    first_sample <= it.first;
    last_sample <= it.last;
    @(posedge clk);
    while (busy) @(posedge clk);
    track_item(it);
    items_sent++;
    pace();
  endtask

  // Hold off until every forecast pick has come back and the pipeline has
  // emptied of samples that close nothing.
  task automatic wait_idle();
    lower_start();
    while (pending_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of the compare width, turned straight into a read-back.
  task automatic program_width(logic [DIST_W-1:0] w);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_ACTIVE_BITS;
    pwdata <= {(APB_DW - DIST_W)'($urandom), w};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    width_setting = w;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== APB_DW'(w))
      report_mismatch($sformatf("active_bits reads back %0d, want %0d", prdata, w));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [DIST_W-1:0] draw_width();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return 7'd64;
    if (roll == 2) return 7'd127;
    if (roll == 3) return DIST_W'($urandom_range(65, 126));
    return DIST_W'($urandom_range(1, 63));
  endfunction

  // One well-formed selection, a load slipped in now and then.
  task automatic run_selection(int unsigned len);
    logic [IN_W-1:0] r;
    r = near_reference();
    for (int unsigned k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(load_item(IDX_W'($urandom), near_reference(),
                            1'($urandom), 1'($urandom)));
      send_item(sample_item(pick_loaded(), r, k == 0, k == len - 1));
    end
  endtask

  // Selections that miss the opening mark or are never closed.
  task automatic run_broken_selection();
    logic [IN_W-1:0] r;
    int unsigned     len;
    bit              unopened;
    r = near_reference();
    len = $urandom_range(1, 4);
    unopened = 1'($urandom);
    for (int unsigned k = 0; k < len; k++) begin
      if (unopened) send_item(sample_item(pick_loaded(), r, 1'b0, k == len - 1));
      else send_item(sample_item(pick_loaded(), r, k == 0, 1'b0));
    end
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0)
      send_item(sample_item(pick_loaded(), rand64(), 1'($urandom), 1'($urandom)));
    else
      send_item(load_item(IDX_W'($urandom), rand64(), 1'($urandom), 1'($urandom)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // A sample with no opening mark straight after reset meets slot 0 at
  // distance 0, which nothing beats. The load carries both marks, which it
  // must ignore.
  task automatic test_held_best_after_reset();
    send_item(load_item(6'd5, '1, 1'b1, 1'b1));
    send_item(sample_item(6'd5, '0, 1'b0, 1'b1));
  endtask

  // Extreme slots and vectors, single-sample selections (first and last
  // together), distances of 0, 32 and 64.
  task automatic test_vector_extremes();
    send_item(load_item(6'd0, '0, 1'b0, 1'b1));
    send_item(load_item(6'd63, '1, 1'b1, 1'b0));
    send_item(sample_item(6'd0, '1, 1'b1, 1'b1));
    send_item(sample_item(6'd63, '1, 1'b1, 1'b1));
    send_item(sample_item(6'd5, 64'h5555_5555_5555_5555, 1'b1, 1'b1));
    send_item(sample_item(6'd0, '0, 1'b1, 1'b1));
  endtask

  // Ties keep the earlier sample, a mid-run load leaves the minimum alone,
  // and a fresh opening mark restarts the minimum inside a run.
  task automatic test_ties_and_restart();
    send_item(load_item(6'd10, 64'h0000_0000_0000_000F, 1'b0, 1'b0));
    send_item(load_item(6'd11, 64'h0000_0000_0000_00F0, 1'b0, 1'b0));
    send_item(load_item(6'd12, 64'h0000_0000_0000_0001, 1'b0, 1'b0));
    send_item(sample_item(6'd10, '0, 1'b1, 1'b0));
    send_item(sample_item(6'd11, '0, 1'b0, 1'b0));
    send_item(sample_item(6'd12, '0, 1'b0, 1'b0));
    send_item(load_item(6'd20, rand64(), 1'b1, 1'b1));
    send_item(sample_item(6'd11, '0, 1'b0, 1'b1));
    send_item(sample_item(6'd12, '0, 1'b1, 1'b0));
    send_item(sample_item(6'd0, '0, 1'b0, 1'b0));
    send_item(sample_item(6'd10, '0, 1'b1, 1'b0));
    send_item(sample_item(6'd11, '0, 1'b0, 1'b1));
  endtask

  // Load every slot so that all of them may be sampled from here on.
  task automatic test_population_fill();
    logic [IN_W-1:0] v;
    for (int s = 0; s < NSLOTS; s++) begin
      if (s == 1) v = '0;
      else if (s == 2) v = '1;
      else v = rand64();
      send_item(load_item(IDX_W'(s), v, 1'($urandom), 1'($urandom)));
    end
  endtask

  // Walk the compare width through its extremes: none, one bit, above the
  // vector width, just below and at it, and a few in between.
  task automatic test_compare_width();
    logic [DIST_W-1:0] widths [9] = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd63,
                                      7'd32, 7'd7, 7'd100, 7'd64};
    widths[7] = DIST_W'($urandom_range(2, 62));
    foreach (widths[i]) begin
      wait_idle();
      program_width(widths[i]);
      repeat (6) run_selection($urandom_range(1, 6));
    end
  endtask

  // Mostly well-formed selections with random content; the rest loads,
  // stray items and broken runs. Every phase ends in a full pause, most
  // with a new width.
  task automatic test_mixed_traffic();
    int unsigned roll;
    int          next_phase;
    next_phase = items_sent;
    while (items_sent < TARGET_ITEMS) begin
      if (items_sent >= next_phase) begin
        wait_idle();
        if ($urandom_range(0, 2) != 0) program_width(draw_width());
        steady = ($urandom_range(0, 3) == 0);
        next_phase = items_sent + 120;
      end
      roll = $urandom_range(0, 99);
      if (roll < 72) begin
        run_selection($urandom_range(1, 8));
      end else if (roll < 82) begin
        repeat ($urandom_range(1, 4))
          send_item(load_item(IDX_W'($urandom), near_reference(), 1'b0, 1'b0));
      end else if (roll < 92) begin
        send_noise();
      end else begin
        run_broken_selection();
      end
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    held_slot = '0;
    held_dist = '0;
    width_setting = ACTIVE_BITS_RESET;
    foreach (loaded[i]) loaded[i] = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_held_best_after_reset();
    test_vector_extremes();
    test_ties_and_restart();
    test_population_fill();
    test_compare_width();
    test_mixed_traffic();

    // drain what is still in flight, with a bound
    lower_start();
    for (int n = 0; n < 200 && pending_picks.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_picks.size() != 0)
      report_mismatch($sformatf("%0d picks never came back", pending_picks.size()));

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* nearest_hamming_member_select.f */
design/nhms_pkg.sv
design/nhms_ram.sv
design/nhms_ctrl.sv
design/nhms_datapath.sv
design/nearest_hamming_member_select.sv
verif/testbench.sv
